FILE: hw/rtl/battery_peak_hold_gauge_core_assert.svh
// Assertion macros shared by the gauge RTL.
// Stand-alone header; it needs nothing else and is included by the top level.
`ifndef BATTERY_PEAK_HOLD_GAUGE_CORE_ASSERT_SVH
`define BATTERY_PEAK_HOLD_GAUGE_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BPHG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gauge assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BPHG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gauge assertion failed");

`endif

FILE: hw/rtl/bphg_pkg.sv
// Shared types and constants of the battery peak-hold gauge.
// No dependencies; used by bphg_mul, bphg_div and the top level.
package bphg_pkg;

	// Field widths.
	localparam int ADC_W     = 12;
	localparam int SUM_W     = 20;
	localparam int IDX_W     = 8;
	localparam int HELD_W    = 24;
	localparam int PCT_W     = 7;
	localparam int CV_W      = 13;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_W     = 20;

	// Serial multiplier: 32-bit multiplicand, 16-bit multiplier.
	localparam int MUL_A_W   = 32;
	localparam int MUL_B_W   = 16;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

	// Serial restoring divider: 48-bit dividend, 24-bit divisor.
	localparam int DIV_DVD_W = 48;
	localparam int DIV_DSR_W = 24;
	localparam int DIV_QUO_W = 24;
	localparam int DIV_CNT_W = $clog2(DIV_DVD_W + 1);

	// Scaling constants: 3.3 V reference in mV, converter full scale,
	// held level per centivolt (10 mV times 256), and one hundred percent.
	localparam int SCALE_MV     = 3300;
	localparam int ADC_FULL     = 4095;
	localparam int GAIN_SHIFT_K = 16;
	localparam int CV_DIV       = 2560;
	localparam int PCT_FULL     = 100;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EMPTY    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FULL     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WARN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CRIT     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd6;

	// Status of a serial arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

FILE: hw/rtl/bphg_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on bphg_pkg.
module bphg_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bphg_pkg::MUL_A_W-1:0]      mcand,
	input  logic [bphg_pkg::MUL_B_W-1:0]      mplier,
	output logic [bphg_pkg::MUL_P_W-1:0]      product,
	output bphg_pkg::unit_stat_t              stat
);
	import bphg_pkg::*;

	logic [MUL_A_W-1:0]   mcand_q;
	logic [MUL_A_W-1:0]   acc_q;
	logic [MUL_B_W-1:0]   lo_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [MUL_A_W:0]     sum;

	// Add the multiplicand when the current multiplier bit is set.
	assign sum = {1'b0, acc_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

	// Sequencing: count the multiplier bits and flag completion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= MUL_CNT_W'(MUL_B_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the low product bits shift in as the multiplier shifts out.
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			acc_q   <= '0;
			lo_q    <= mplier;
		end else if (busy_q) begin
			acc_q <= sum[MUL_A_W:1];
			lo_q  <= {sum[0], lo_q[MUL_B_W-1:1]};
		end
	end

	assign product   = {acc_q, lo_q};
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: hw/rtl/bphg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bphg_pkg. The dividend is given left-aligned with a step count.
module bphg_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [bphg_pkg::DIV_DVD_W-1:0]    dividend,
	input  logic [bphg_pkg::DIV_DSR_W-1:0]    divisor,
	input  logic [bphg_pkg::DIV_CNT_W-1:0]    steps,
	output logic [bphg_pkg::DIV_QUO_W-1:0]    quotient,
	output bphg_pkg::unit_stat_t              stat
);
	import bphg_pkg::*;

	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DIV_DSR_W-1:0] dsr_q;
	logic [DIV_DSR_W-1:0] rem_q;
	logic [DIV_QUO_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DSR_W:0]   trial;
	logic [DIV_DSR_W:0]   diff;
	logic                 fits;

	// Bring down the next dividend bit and try the divisor against it.
	assign trial = {rem_q, dvd_q[DIV_DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	// Sequencing: count the quotient bits and flag completion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the remainder always stays below the divisor.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], 1'b0};
			rem_q <= fits ? diff[DIV_DSR_W-1:0] : trial[DIV_DSR_W-1:0];
			quo_q <= {quo_q[DIV_QUO_W-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: hw/rtl/battery_peak_hold_gauge_core.sv
// Battery peak-hold gauge: sample averaging, held level with decay, charge percentage.
// Depends on bphg_pkg, bphg_mul, bphg_div and battery_peak_hold_gauge_core_assert.svh.
//
//   channel | signals                           | word
//   --------+-----------------------------------+----------------------------------------
//   in      | in_valid, in_ready                | adc_sample
//   out     | out_valid, out_ready              | reading_voltage, held_voltage, charge
//           |                                   | percent, low/critical/start flags
//   cfg     | cfg_we, cfg_index, cfg_data       | one register write, no wait
//
// A sample that does not close a group leaves in_ready high. The closing sample holds
// in_ready low through the update: set-up, multiply, divide, decay multiply (only when
// the held level decays), centivolt divide, percent divide (skipped with equal empty and
// full), word load. A word still waiting on out_ready keeps the next update in its last
// state, in_ready low. Reset is asynchronous, active low.
`include "battery_peak_hold_gauge_core_assert.svh"

module battery_peak_hold_gauge_core #(
	parameter int SAMPLE_COUNT = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [bphg_pkg::ADC_W-1:0]      adc_sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [bphg_pkg::HELD_W-1:0]     reading_voltage,
	output logic [bphg_pkg::HELD_W-1:0]     held_voltage,
	output logic [bphg_pkg::PCT_W-1:0]      charge_percent,
	output logic                            low_flag,
	output logic                            critical_flag,
	output logic                            start_allowed,
	input  logic                            cfg_we,
	input  logic [bphg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bphg_pkg::CFG_W-1:0]      cfg_data
);
	import bphg_pkg::*;

	// Divisor of the reading: samples per group times converter full scale times 16.
	localparam logic [DIV_DSR_W-1:0] READ_DEN =
		DIV_DSR_W'(SAMPLE_COUNT * ADC_FULL * GAIN_SHIFT_K);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCALE,
		S_MUL_RD,
		S_DIV_RD,
		S_MUL_DK,
		S_CV_GO,
		S_CV_WAIT,
		S_PCT_GO,
		S_PCT_WAIT,
		S_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [CFG_W-1:0] gain_q;
	logic [CFG_W-1:0] decay_q;
	logic [CV_W-1:0]  empty_q;
	logic [CV_W-1:0]  full_q;
	logic [PCT_W-1:0] warn_q;
	logic [PCT_W-1:0] crit_q;
	logic [PCT_W-1:0] start_q;

	// Accumulation and held state.
	logic [SUM_W-1:0]  sum_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SUM_W-1:0]  grp_sum_q;
	logic [HELD_W-1:0] held_q;
	logic              primed_q;
	logic [HELD_W-1:0] reading_q;

	// Percentage mapping.
	logic [NUM_W-1:0]  num_mag_q;
	logic [CV_W-1:0]   span_mag_q;
	logic              neg_q;
	logic              span_zero_q;
	logic [PCT_W-1:0]  pct_q;

	// Output word.
	logic              out_valid_q;
	logic [HELD_W-1:0] out_reading_q;
	logic [HELD_W-1:0] out_held_q;
	logic [PCT_W-1:0]  out_pct_q;
	logic              out_low_q;
	logic              out_crit_q;
	logic              out_start_q;

	// Shared serial units.
	logic                 mul_start;
	logic [MUL_A_W-1:0]   mul_mcand;
	logic [MUL_B_W-1:0]   mul_mplier;
	logic [MUL_P_W-1:0]   mul_prod;
	unit_stat_t           mul_stat;
	logic                 div_start;
	logic [DIV_DVD_W-1:0] div_dvd;
	logic [DIV_DSR_W-1:0] div_dsr;
	logic [DIV_CNT_W-1:0] div_steps;
	logic [DIV_QUO_W-1:0] div_quo;
	unit_stat_t           div_stat;

	// Combinational helpers.
	logic              in_fire;
	logic [SUM_W-1:0]  sum_next;
	logic [IDX_W-1:0]  idx_next;
	logic              grp_full;
	logic [HELD_W-1:0] gap;
	logic [CV_W-1:0]   cv;
	logic signed [CV_W+1:0]  diff_s;
	logic signed [CV_W+1:0]  span_s;
	logic signed [NUM_W+1:0] num_s;
	logic [NUM_W+1:0]        num_abs;
	logic [CV_W+1:0]         span_abs;

	bphg_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_mcand),
		.mplier  (mul_mplier),
		.product (mul_prod),
		.stat    (mul_stat)
	);

	bphg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.steps    (div_steps),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= CFG_W'(16384);
			decay_q <= CFG_W'(655);
			empty_q <= CV_W'(600);
			full_q  <= CV_W'(840);
			warn_q  <= PCT_W'(20);
			crit_q  <= PCT_W'(10);
			start_q <= PCT_W'(15);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN:  gain_q  <= cfg_data;
				REG_DECAY: decay_q <= cfg_data;
				REG_EMPTY: empty_q <= cfg_data[CV_W-1:0];
				REG_FULL:  full_q  <= cfg_data[CV_W-1:0];
				REG_WARN:  warn_q  <= cfg_data[PCT_W-1:0];
				REG_CRIT:  crit_q  <= cfg_data[PCT_W-1:0];
				REG_START: start_q <= cfg_data[PCT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Group accounting for the incoming sample.
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign sum_next = sum_q + SUM_W'(adc_sample);
	assign idx_next = idx_q + 1'b1;
	assign grp_full = (idx_next == '0) || ({1'b0, idx_next} >= (IDX_W+1)'(SAMPLE_COUNT));

	// Signed mapping of centivolts onto the empty..full span.
	assign gap      = held_q - div_quo;
	assign cv       = div_quo[CV_W-1:0];
	assign diff_s   = $signed({2'b00, cv}) - $signed({2'b00, empty_q});
	assign span_s   = $signed({2'b00, full_q}) - $signed({2'b00, empty_q});
	assign num_s    = (NUM_W+2)'(diff_s) * $signed((NUM_W+2)'(PCT_FULL));
	assign num_abs  = num_s[NUM_W+1] ? (NUM_W+2)'(-num_s) : num_s;
	assign span_abs = span_s[CV_W+1] ? (CV_W+2)'(-span_s) : span_s;

	// Operand selection for the serial units.
	always_comb begin
		mul_start  = 1'b0;
		mul_mcand  = '0;
		mul_mplier = '0;
		div_start  = 1'b0;
		div_dvd    = '0;
		div_dsr    = '0;
		div_steps  = '0;
		case (state_q)
			S_SCALE: begin
				mul_start  = 1'b1;
				mul_mcand  = MUL_A_W'({12'b0, grp_sum_q} * 32'(SCALE_MV));
				mul_mplier = gain_q;
			end
			S_MUL_RD: begin
				div_start = mul_stat.done;
				div_dvd   = mul_prod;
				div_dsr   = READ_DEN;
				div_steps = DIV_CNT_W'(DIV_DVD_W);
			end
			S_DIV_RD: begin
				mul_start  = div_stat.done && primed_q && (div_quo < held_q);
				mul_mcand  = MUL_A_W'(gap);
				mul_mplier = decay_q;
			end
			S_CV_GO: begin
				div_start = 1'b1;
				div_dvd   = {held_q, (DIV_DVD_W-HELD_W)'(0)};
				div_dsr   = DIV_DSR_W'(CV_DIV);
				div_steps = DIV_CNT_W'(HELD_W);
			end
			S_PCT_GO: begin
				div_start = !span_zero_q;
				div_dvd   = {num_mag_q, (DIV_DVD_W-NUM_W)'(0)};
				div_dsr   = DIV_DSR_W'(span_mag_q);
				div_steps = DIV_CNT_W'(NUM_W);
			end
			default: begin
			end
		endcase
	end

	// Update sequencer and output word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			sum_q         <= '0;
			idx_q         <= '0;
			grp_sum_q     <= '0;
			held_q        <= '0;
			primed_q      <= 1'b0;
			reading_q     <= '0;
			num_mag_q     <= '0;
			span_mag_q    <= '0;
			neg_q         <= 1'b0;
			span_zero_q   <= 1'b0;
			pct_q         <= '0;
			out_valid_q   <= 1'b0;
			out_reading_q <= '0;
			out_held_q    <= '0;
			out_pct_q     <= '0;
			out_low_q     <= 1'b0;
			out_crit_q    <= 1'b0;
			out_start_q   <= 1'b0;
		end else begin
			// A taken word clears the valid flag unless a new word replaces it.
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (grp_full) begin
							grp_sum_q <= sum_next;
							sum_q     <= '0;
							idx_q     <= '0;
							state_q   <= S_SCALE;
						end else begin
							sum_q <= sum_next;
							idx_q <= idx_next;
						end
					end
				end
				S_SCALE: begin
					state_q <= S_MUL_RD;
				end
				S_MUL_RD: begin
					if (mul_stat.done) begin
						state_q <= S_DIV_RD;
					end
				end
				S_DIV_RD: begin
					// A reading at or above the held level, or the first one, is adopted at once.
					if (div_stat.done) begin
						reading_q <= div_quo;
						if (!primed_q || div_quo >= held_q) begin
							held_q   <= div_quo;
							primed_q <= 1'b1;
							state_q  <= S_CV_GO;
						end else begin
							state_q <= S_MUL_DK;
						end
					end
				end
				S_MUL_DK: begin
					// Close the floored fraction of the gap.
					if (mul_stat.done) begin
						held_q  <= held_q - mul_prod[MUL_B_W +: HELD_W];
						state_q <= S_CV_GO;
					end
				end
				S_CV_GO: begin
					state_q <= S_CV_WAIT;
				end
				S_CV_WAIT: begin
					if (div_stat.done) begin
						num_mag_q   <= num_abs[NUM_W-1:0];
						span_mag_q  <= span_abs[CV_W-1:0];
						neg_q       <= num_s[NUM_W+1] ^ span_s[CV_W+1];
						span_zero_q <= (span_s == '0);
						state_q     <= S_PCT_GO;
					end
				end
				S_PCT_GO: begin
					// Equal empty and full voltage gives zero percent.
					if (span_zero_q) begin
						pct_q   <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_PCT_WAIT;
					end
				end
				S_PCT_WAIT: begin
					// A negative quotient clamps to zero, a large one to a hundred.
					if (div_stat.done) begin
						if (neg_q) begin
							pct_q <= '0;
						end else if (div_quo > DIV_QUO_W'(PCT_FULL)) begin
							pct_q <= PCT_W'(PCT_FULL);
						end else begin
							pct_q <= div_quo[PCT_W-1:0];
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						out_reading_q <= reading_q;
						out_held_q    <= held_q;
						out_pct_q     <= pct_q;
						out_low_q     <= (pct_q <= warn_q);
						out_crit_q    <= (pct_q <= crit_q);
						out_start_q   <= (pct_q > start_q);
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign reading_voltage = out_reading_q;
	assign held_voltage    = out_held_q;
	assign charge_percent  = out_pct_q;
	assign low_flag        = out_low_q;
	assign critical_flag   = out_crit_q;
	assign start_allowed   = out_start_q;

	// The two serial units never run at the same time.
	`BPHG_ASSERT_NOW(a_units_exclusive, clk, arst_n, mul_stat.busy, !div_stat.busy)
	// After any update the held level is never below the reading.
	`BPHG_ASSERT_NOW(a_held_over_reading, clk, arst_n, state_q == S_CV_GO, held_q >= reading_q)
	// Between samples the group count stays below the group size.
	`BPHG_ASSERT_NOW(a_index_in_group, clk, arst_n, state_q == S_IDLE,
		(idx_q == '0) || ({1'b0, idx_q} < (IDX_W+1)'(SAMPLE_COUNT)))
	// A delivered percentage is within 0..100.
	`BPHG_ASSERT_NEXT(a_pct_range, clk, arst_n, state_q == S_DONE,
		charge_percent <= PCT_W'(PCT_FULL))

endmodule
